>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker of this block.
// Needs nothing else; each takes a label, clock, reset and a property or ante, cons.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define NTC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ntc assertion failed");

// Implication checked at every rising clock edge outside reset.
`define NTC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ntc implication failed");

`endif

>>> rtl/core/ntc_pkg.sv
// Shared types and constants of the NTC thermistor converter.
// Depends on nothing; every other file of the block but assert_macros.svh uses it.
package ntc_pkg;

	localparam int ADC_BITS_DEF  = 12;
	localparam int FRAC_BITS_DEF = 16;

	localparam int LOG_IN_W  = 20;
	localparam int LOG_INT_W = 5;
	localparam int MANT_BITS = 30;
	localparam int QUOT_W    = 16;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam int KELVIN_CENTI = 27315;
	localparam int TEMP_MAX     = 32767;
	localparam int TK_MAX       = 60082;

	localparam logic [1:0] CFG_SERIES  = 2'd0;
	localparam logic [1:0] CFG_NOMINAL = 2'd1;
	localparam logic [1:0] CFG_BETA    = 2'd2;
	localparam logic [1:0] CFG_T0      = 2'd3;

	localparam logic [19:0] SERIES_RST  = 20'd10000;
	localparam logic [19:0] NOMINAL_RST = 20'd10000;
	localparam logic [13:0] BETA_RST    = 14'd3950;
	localparam logic [14:0] T0_RST      = 15'd2500;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FAULT = 2'd1;
	localparam logic [1:0] ST_RAIL  = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	typedef struct packed {
		logic [ADC_BITS_DEF-1:0] raw_sample;
		logic                    adc_fault;
	} in_t;

	typedef struct packed {
		logic signed [15:0] temperature_centi_c;
		logic [1:0]         status;
	} out_t;

endpackage

>>> rtl/core/ntc_thermistor_to_temperature.sv
// Top level of the NTC thermistor converter: registers, log lanes, beta math, divider, output.
// Depends on ntc_pkg, ntc_log2 and ntc_divider.

// Converts one converter sample of a divider with the thermistor on the lower leg into a
// temperature in hundredths of a degree Celsius using the beta equation. The block accepts
// one transaction every clock cycle while the output is not stalled, and it delivers
// results in order from a pipeline made of one normalize stage and
// FRAC_BITS squaring stages of the base-2 logarithm lanes, five stages of beta arithmetic,
// sixteen restoring-divider stages and the output register. The whole pipeline advances
// together whenever the output register is empty or its transaction is taken, so a stall
// on the output holds every stage in place. A faulted converter read gives status 1 and
// temperature 0, a sample of 0 or full scale gives status 2 and temperature 0, and a result
// that cannot be represented (non-positive inverse temperature or above 327.67 C) gives
// status 3 and temperature 32767. Configuration writes land at once and must only be made
// while no transaction is in flight.
module ntc_thermistor_to_temperature #(
	parameter int FRAC_BITS = ntc_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ntc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ntc_pkg::out_t out_data,
	input  logic          cfg_write,
	input  logic [1:0]    cfg_index,
	input  logic [19:0]   cfg_data
);

	// The sample width is fixed by the input transaction type.
	localparam int ADC_BITS = ntc_pkg::ADC_BITS_DEF;

	localparam int XW    = ntc_pkg::LOG_IN_W;
	localparam int LW    = ntc_pkg::LOG_INT_W + FRAC_BITS;
	localparam int L2W   = FRAC_BITS + 7;
	localparam int MAGW  = FRAC_BITS + 6;
	localparam int PRW   = MAGW + 30;
	localparam int LQTW  = L2W + 17;
	localparam int DENW  = FRAC_BITS + 25;
	localparam int UDW   = FRAC_BITS + 24;
	localparam int NBW   = 37;
	localparam int NUMW  = FRAC_BITS + 38;
	localparam int QW    = ntc_pkg::QUOT_W;
	localparam int CMPW  = UDW + QW;

	// Configuration registers.
	logic [19:0]        series_q;
	logic [19:0]        nominal_q;
	logic [13:0]        beta_q;
	logic signed [14:0] t0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q  <= ntc_pkg::SERIES_RST;
			nominal_q <= ntc_pkg::NOMINAL_RST;
			beta_q    <= ntc_pkg::BETA_RST;
			t0_q      <= ntc_pkg::T0_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ntc_pkg::CFG_SERIES:  series_q  <= cfg_data;
				ntc_pkg::CFG_NOMINAL: nominal_q <= cfg_data;
				ntc_pkg::CFG_BETA:    beta_q    <= cfg_data[13:0];
				ntc_pkg::CFG_T0:      t0_q      <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Derived values; the user, not the block, keeps them put while transactions are in flight.
	// A zero beta register counts as one; zero resistors are handled in the log lanes.
	logic [13:0]        beta_eff;
	logic [20:0]        b100;
	logic signed [16:0] t0c;

	assign beta_eff = (beta_q == '0) ? 14'd1 : beta_q;
	assign b100     = 21'(beta_eff) * 21'd100;
	assign t0c      = 17'(t0_q) + 17'(ntc_pkg::KELVIN_CENTI);

	// The whole pipeline moves when the output register is free or being drained.
	logic adv;
	logic out_valid_q;
	ntc_pkg::out_t out_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Input classification and the two sample-dependent log arguments.
	localparam logic [16:0] FULL = 17'((1 << ADC_BITS) - 1);

	logic [16:0] raw_m;
	logic [1:0]  st_in;
	logic [XW-1:0] x_raw;
	logic [XW-1:0] x_rest;

	assign raw_m  = 17'(in_data.raw_sample) & FULL;
	assign x_raw  = XW'(raw_m);
	assign x_rest = XW'(FULL - raw_m);

	always_comb begin
		priority if (in_data.adc_fault) begin
			st_in = ntc_pkg::ST_FAULT;
		end else if (raw_m == '0 || raw_m >= FULL) begin
			st_in = ntc_pkg::ST_RAIL;
		end else begin
			st_in = ntc_pkg::ST_OK;
		end
	end

	// Four log lanes run in lockstep; the raw lane carries the valid bit and status.
	logic [LW-1:0] log_s;
	logic [LW-1:0] log_r;
	logic [LW-1:0] log_f;
	logic [LW-1:0] log_n;
	logic          lv;
	logic [1:0]    lst;
	logic          lv_s_unused;
	logic          lv_f_unused;
	logic          lv_n_unused;
	logic [1:0]    lt_s_unused;
	logic [1:0]    lt_f_unused;
	logic [1:0]    lt_n_unused;

	ntc_log2 #(.FRAC_BITS(FRAC_BITS), .TAG_W(2)) u_log_series (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(1'b0),
		.x(series_q), .tag_in(2'b00),
		.out_valid(lv_s_unused), .log_out(log_s), .tag_out(lt_s_unused)
	);

	ntc_log2 #(.FRAC_BITS(FRAC_BITS), .TAG_W(2)) u_log_raw (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(in_valid),
		.x(x_raw), .tag_in(st_in),
		.out_valid(lv), .log_out(log_r), .tag_out(lst)
	);

	ntc_log2 #(.FRAC_BITS(FRAC_BITS), .TAG_W(2)) u_log_rest (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(1'b0),
		.x(x_rest), .tag_in(2'b00),
		.out_valid(lv_f_unused), .log_out(log_f), .tag_out(lt_f_unused)
	);

	ntc_log2 #(.FRAC_BITS(FRAC_BITS), .TAG_W(2)) u_log_nominal (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(1'b0),
		.x(nominal_q), .tag_in(2'b00),
		.out_valid(lv_n_unused), .log_out(log_n), .tag_out(lt_n_unused)
	);

	// Stage 1: sum of the logs and the numerator base 100*B*T0.
	logic signed [L2W-1:0] l2_s1;
	logic [NBW-1:0]        nb_s1;
	logic [1:0]            st_s1;
	logic                  v_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			l2_s1 <= L2W'(log_s) + L2W'(log_r) - L2W'(log_f) - L2W'(log_n);
			nb_s1 <= NBW'(b100) * NBW'(t0c[15:0]);
			st_s1 <= lst;
		end
	end

	// Stage 2: magnitude of the log sum times ln 2.
	logic [MAGW-1:0] mag;
	logic [PRW-1:0]  prod_s2;
	logic            neg_s2;
	logic [NBW-1:0]  nb_s2;
	logic [1:0]      st_s2;
	logic            v_s2;

	assign mag = (l2_s1 < 0) ? MAGW'(-l2_s1) : MAGW'(l2_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= PRW'(mag) * PRW'(ntc_pkg::LN2_Q30);
			neg_s2  <= l2_s1 < 0;
			nb_s2   <= nb_s1;
			st_s2   <= st_s1;
		end
	end

	// Stage 3: round to the natural log and scale it by T0.
	logic [PRW-1:0]         rnd;
	logic signed [L2W-1:0]  lq;
	logic signed [LQTW-1:0] lqt_s3;
	logic [NBW-1:0]         nb_s3;
	logic [1:0]             st_s3;
	logic                   v_s3;

	assign rnd = prod_s2 + (PRW'(1) << 29);
	assign lq  = neg_s2 ? -L2W'(rnd[PRW-1:30]) : L2W'(rnd[PRW-1:30]);

	always_ff @(posedge clk) begin
		if (adv) begin
			lqt_s3 <= LQTW'(lq) * LQTW'(t0c);
			nb_s3  <= nb_s2;
			st_s3  <= st_s2;
		end
	end

	// Stage 4: denominator and the non-positive inverse temperature check.
	logic [DENW-1:0]        bsh;
	logic signed [DENW-1:0] den;
	logic [DENW-1:0]        den_s4;
	logic [NBW-1:0]         nb_s4;
	logic [1:0]             st_s4;
	logic                   v_s4;

	assign bsh = DENW'(b100) << FRAC_BITS;
	assign den = $signed(bsh) + DENW'(lqt_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s4 <= den;
			nb_s4  <= nb_s3;
			if (st_s3 == ntc_pkg::ST_OK && (t0c <= 0 || den <= 0)) begin
				st_s4 <= ntc_pkg::ST_SAT;
			end else begin
				st_s4 <= st_s3;
			end
		end
	end

	// Stage 5: rounded numerator and the check that the quotient fits its width.
	logic [UDW-1:0]  ud;
	logic [NUMW-1:0] numr;
	logic [NUMW-1:0] num_s5;
	logic [UDW-1:0]  ud_s5;
	logic [2:0]      tag_s5;
	logic            v_s5;

	assign ud   = den_s4[UDW-1:0];
	assign numr = (NUMW'(nb_s4) << FRAC_BITS) + NUMW'(ud >> 1);

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5 <= numr;
			ud_s5  <= ud;
			tag_s5 <= {CMPW'(numr) >= (CMPW'(ud) << QW), st_s4};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= lv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Divider: temperature in centi-kelvin, round half up.
	logic          dv;
	logic [QW-1:0] tk;
	logic [2:0]    dtag;

	ntc_divider #(.NUM_W(NUMW), .DEN_W(UDW), .Q_W(QW), .TAG_W(3)) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s5),
		.num(num_s5), .den(ud_s5), .tag_in(tag_s5),
		.out_valid(dv), .quot(tk), .tag_out(dtag)
	);

	// Output register: status priority and saturation.
	ntc_pkg::out_t res;

	always_comb begin
		res.status              = dtag[1:0];
		res.temperature_centi_c = '0;
		if (dtag[1:0] == ntc_pkg::ST_SAT) begin
			res.temperature_centi_c = 16'(ntc_pkg::TEMP_MAX);
		end else if (dtag[1:0] == ntc_pkg::ST_OK) begin
			if (dtag[2] || tk > QW'(ntc_pkg::TK_MAX)) begin
				res.status              = ntc_pkg::ST_SAT;
				res.temperature_centi_c = 16'(ntc_pkg::TEMP_MAX);
			end else begin
				res.temperature_centi_c = 16'(tk - QW'(ntc_pkg::KELVIN_CENTI));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/core/ntc_log2.sv
// Pipelined base-2 logarithm: one normalize stage, then one squaring stage per fraction bit.
// Depends on ntc_pkg.
module ntc_log2 #(
	parameter int FRAC_BITS = ntc_pkg::FRAC_BITS_DEF,
	parameter int TAG_W     = 2
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     in_valid,
	input  logic [ntc_pkg::LOG_IN_W-1:0]             x,
	input  logic [TAG_W-1:0]                         tag_in,
	output logic                                     out_valid,
	output logic [ntc_pkg::LOG_INT_W+FRAC_BITS-1:0]  log_out,
	output logic [TAG_W-1:0]                         tag_out
);

	localparam int XW = ntc_pkg::LOG_IN_W;
	localparam int NW = ntc_pkg::LOG_INT_W;
	localparam int MB = ntc_pkg::MANT_BITS;

	logic [XW-1:0] xe;
	logic [NW-1:0] lead;
	logic [MB:0]   mant0;

	logic [MB:0]        mant_s [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] frac_s [FRAC_BITS+1];
	logic [NW-1:0]      n_s    [FRAC_BITS+1];
	logic [TAG_W-1:0]   tag_s  [FRAC_BITS+1];
	logic               v_s    [FRAC_BITS+1];

	// Zero is taken as one.
	assign xe = (x == '0) ? XW'(1) : x;

	always_comb begin
		lead = '0;
		for (int i = 0; i < XW; i++) begin
			if (xe[i]) begin
				lead = NW'(i);
			end
		end
	end

	assign mant0 = (MB+1)'(({xe, {MB{1'b0}}}) >> lead);

	always_ff @(posedge clk) begin
		if (en) begin
			mant_s[0] <= mant0;
			frac_s[0] <= '0;
			n_s[0]    <= lead;
			tag_s[0]  <= tag_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
		logic [2*MB+1:0] sq;
		logic [MB+1:0]   t;
		assign sq = {{(MB+1){1'b0}}, mant_s[k]} * {{(MB+1){1'b0}}, mant_s[k]};
		assign t  = sq[2*MB+1:MB];

		always_ff @(posedge clk) begin
			if (en) begin
				mant_s[k+1] <= t[MB+1] ? t[MB+1:1] : t[MB:0];
				frac_s[k+1] <= {frac_s[k][FRAC_BITS-2:0], t[MB+1]};
				n_s[k+1]    <= n_s[k];
				tag_s[k+1]  <= tag_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	assign out_valid = v_s[FRAC_BITS];
	assign log_out   = {n_s[FRAC_BITS], frac_s[FRAC_BITS]};
	assign tag_out   = tag_s[FRAC_BITS];

endmodule

>>> rtl/core/ntc_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ntc_pkg for the default quotient width.
module ntc_divider #(
	parameter int NUM_W = 54,
	parameter int DEN_W = 40,
	parameter int Q_W   = ntc_pkg::QUOT_W,
	parameter int TAG_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   quot,
	output logic [TAG_W-1:0] tag_out
);

	localparam int CW = (DEN_W + Q_W > NUM_W) ? DEN_W + Q_W : NUM_W;

	logic [NUM_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W];
	logic [TAG_W-1:0] tag_s [Q_W];
	logic             v_s   [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [NUM_W-1:0] rem_c;
		logic [DEN_W-1:0] den_c;
		logic [Q_W-1:0]   q_c;
		logic [TAG_W-1:0] tag_c;
		logic             v_c;
		logic [CW-1:0]    dsh;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_c = num;
			assign den_c = den;
			assign q_c   = '0;
			assign tag_c = tag_in;
			assign v_c   = in_valid;
		end else begin : g_rest
			assign rem_c = rem_s[k-1];
			assign den_c = den_s[k-1];
			assign q_c   = q_s[k-1];
			assign tag_c = tag_s[k-1];
			assign v_c   = v_s[k-1];
		end

		assign dsh = CW'(den_c) << (Q_W - 1 - k);
		assign ge  = CW'(rem_c) >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? NUM_W'(CW'(rem_c) - dsh) : rem_c;
				den_s[k] <= den_c;
				q_s[k]   <= {q_c[Q_W-2:0], ge};
				tag_s[k] <= tag_c;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_c;
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign quot      = q_s[Q_W-1];
	assign tag_out   = tag_s[Q_W-1];

endmodule

>>> rtl/core/ntc_checker.sv
// Port-level checker for the NTC thermistor converter, bound to the top level.
// Depends on ntc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ntc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input ntc_pkg::out_t out_data
);

	// A waiting result holds its value.
	`NTC_ASSERT_IMP(a_out_hold, clk, arst_n, out_valid && !out_ready, ##1 (out_valid && $stable(out_data)))

	// An empty output stage never blocks the input.
	`NTC_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready)

	// Fault and rail results carry a zero temperature.
	`NTC_ASSERT_IMP(a_zero_temp, clk, arst_n, out_valid && (out_data.status == ntc_pkg::ST_FAULT || out_data.status == ntc_pkg::ST_RAIL), out_data.temperature_centi_c == 16'sd0)

	// Saturated results carry the top value.
	`NTC_ASSERT_IMP(a_sat_temp, clk, arst_n, out_valid && out_data.status == ntc_pkg::ST_SAT, out_data.temperature_centi_c == 16'sd32767)

	// A good result never lies below absolute zero.
	`NTC_ASSERT_IMP(a_abs_zero, clk, arst_n, out_valid && out_data.status == ntc_pkg::ST_OK, out_data.temperature_centi_c >= -16'sd27315)

endmodule

bind ntc_thermistor_to_temperature ntc_checker u_ntc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

>>> tb/testbench.sv
// Self-checking testbench for ntc_thermistor_to_temperature (beta-equation thermistor converter).
// Depends on ntc_pkg and the RTL of the block; a bit-exact fixed-point predictor checks every result.
`timescale 1ns / 1ps

module testbench;

	localparam int FULL_CODE   = 4095;
	localparam int DRAIN_WAIT  = 45;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ntc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ntc_pkg::out_t out_data;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = ntc_pkg::CFG_SERIES;
	logic [19:0] cfg_data = '0;

	// Our own copy of the configuration registers, updated as they are written.
	logic [19:0] series_ohm = ntc_pkg::SERIES_RST;
	logic [19:0] nominal_ohm = ntc_pkg::NOMINAL_RST;
	logic [13:0] beta_k = ntc_pkg::BETA_RST;
	logic signed [14:0] t0_centi = ntc_pkg::T0_RST;

	ntc_pkg::in_t pending_samples[$];
	ntc_pkg::out_t expected_temps[$];

	int send_idle_pct = 10;
	int recv_idle_pct = 10;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int mismatches = 0;
	longint cycles = 0;

	ntc_thermistor_to_temperature u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Base-2 logarithm with 16 fraction bits: integer part from the top set bit, then
	// one fraction bit per squaring of a Q30 mantissa.
	function automatic longint log2_q16(input logic [31:0] x);
		int n;
		logic [63:0] m;
		longint frac;
		n = 0;
		frac = 0;
		if (x == 0) x = 1;
		while (n < 31 && (x >> (n + 1)) != 0) n++;
		m = (64'(x) << 30) >> n;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(n) << 16) | frac;
	endfunction

	// Expected temperature and status for one sample under the current register values.
	function automatic ntc_pkg::out_t predict_temperature(input ntc_pkg::in_t s);
		ntc_pkg::out_t r;
		longint raw, ser, r0, b, t0c, l2, mag, lq, den, num, tk;
		r.temperature_centi_c = '0;
		r.status = ntc_pkg::ST_OK;
		raw = s.raw_sample;
		if (s.adc_fault) begin
			r.status = ntc_pkg::ST_FAULT;
		end else if (raw == 0 || raw >= FULL_CODE) begin
			r.status = ntc_pkg::ST_RAIL;
		end else begin
			// A zero resistor or beta register counts as one.
			ser = (series_ohm != 0) ? series_ohm : 1;
			r0 = (nominal_ohm != 0) ? nominal_ohm : 1;
			b = (beta_k != 0) ? beta_k : 1;
			t0c = longint'(t0_centi) + ntc_pkg::KELVIN_CENTI;
			l2 = log2_q16(ser) + log2_q16(raw) - log2_q16(FULL_CODE - raw) - log2_q16(r0);
			mag = (l2 < 0) ? -l2 : l2;
			lq = (mag * longint'(ntc_pkg::LN2_Q30) + (longint'(1) << 29)) >>> 30;
			if (l2 < 0) lq = -lq;
			den = ((100 * b) << 16) + lq * t0c;
			if (t0c <= 0 || den <= 0) begin
				r.temperature_centi_c = 16'(ntc_pkg::TEMP_MAX);
				r.status = ntc_pkg::ST_SAT;
			end else begin
				num = (100 * b * t0c) << 16;
				tk = (num + den / 2) / den;
				if (tk > ntc_pkg::TK_MAX) begin
					r.temperature_centi_c = 16'(ntc_pkg::TEMP_MAX);
					r.status = ntc_pkg::ST_SAT;
				end else begin
					r.temperature_centi_c = 16'(tk - ntc_pkg::KELVIN_CENTI);
				end
			end
		end
		return r;
	endfunction

	// Driver: offers queued samples, with random idle bursts, and records the expected
	// result of every accepted transaction.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_temps.push_back(predict_temperature(in_data));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() > 0 &&
						$urandom_range(99, 0) < send_idle_pct) begin
					send_gap = $urandom_range(10, 0);
					in_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: applies back-pressure in bursts (and one long hold on request) and
	// compares each delivered transaction against the oldest expectation.
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_temps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: temp %0d status %0d",
							out_data.temperature_centi_c, out_data.status);
				end else begin
					ntc_pkg::out_t want;
					want = expected_temps.pop_front();
					if (want.temperature_centi_c !== out_data.temperature_centi_c ||
							want.status !== out_data.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
								want.temperature_centi_c, want.status,
								out_data.temperature_centi_c, out_data.status);
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				recv_gap = LONG_HOLD;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if ($urandom_range(99, 0) < recv_idle_pct) begin
				recv_gap = $urandom_range(10, 0);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** ntc_thermistor_to_temperature: FAILED **");
			$finish;
		end
	end

	// Register write through the plain write port; our register copy follows it.
	task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		unique case (idx)
			ntc_pkg::CFG_SERIES: series_ohm = val;
			ntc_pkg::CFG_NOMINAL: nominal_ohm = val;
			ntc_pkg::CFG_BETA: beta_k = val[13:0];
			ntc_pkg::CFG_T0: t0_centi = val[14:0];
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_all(input logic [19:0] ser, input logic [19:0] nom,
			input logic [13:0] b, input logic signed [14:0] t0);
		write_reg(ntc_pkg::CFG_SERIES, ser);
		write_reg(ntc_pkg::CFG_NOMINAL, nom);
		write_reg(ntc_pkg::CFG_BETA, 20'(b));
		write_reg(ntc_pkg::CFG_T0, 20'(t0));
	endtask

	// Queue count random samples; the divider codes are mostly valid, with some rail codes and faults.
	task automatic queue_random(input int count);
		ntc_pkg::in_t s;
		for (int i = 0; i < count; i++) begin
			s.raw_sample = 12'($urandom_range(4094, 1));
			if ($urandom_range(19, 0) == 0) s.raw_sample = $urandom_range(1, 0) ? 12'd0 : 12'hFFF;
			if ($urandom_range(9, 0) == 0) s.raw_sample = 12'($urandom);
			s.adc_fault = ($urandom_range(11, 0) == 0);
			pending_samples.push_back(s);
		end
	endtask

	// Block until the sender has nothing left and every expectation has been met,
	// then let the pipeline settle so a configuration write is safe.
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending_samples.size() != 0 || in_valid || expected_temps.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		ntc_pkg::in_t s;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples at reset settings: rails, mid-scale, extremes and faults.
		for (int i = 0; i < 12; i++) begin
			s.adc_fault = 1'b0;
			case (i)
				0: s.raw_sample = 12'd0;
				1: s.raw_sample = 12'd1;
				2: s.raw_sample = 12'd2;
				3: s.raw_sample = 12'd1024;
				4: s.raw_sample = 12'd2047;
				5: s.raw_sample = 12'd2048;
				6: s.raw_sample = 12'd3000;
				7: s.raw_sample = 12'd4093;
				8: s.raw_sample = 12'd4094;
				9: s.raw_sample = 12'd4095;
				10: s.raw_sample = 12'hAAA;
				default: s.raw_sample = 12'h555;
			endcase
			pending_samples.push_back(s);
		end
		s.adc_fault = 1'b1;
		s.raw_sample = 12'd2048;
		pending_samples.push_back(s);
		s.raw_sample = 12'd0;
		pending_samples.push_back(s);
		s.raw_sample = 12'hFFF;
		pending_samples.push_back(s);
		drain();

		// Largest series, beta and T0 registers: a large-beta part with a large nominal resistor.
		set_all(20'hFFFFF, 20'd1000000, 14'h3FFF, 15'sd16383);
		for (int i = 0; i < 6; i++) begin
			s.adc_fault = 1'b0;
			s.raw_sample = (i == 0) ? 12'd1 : (i == 1) ? 12'd4094 : 12'(i * 700);
			pending_samples.push_back(s);
		end
		queue_random(120);
		drain();

		// Zero and minimum registers; zero resistor and beta are treated as one.
		set_all(20'd0, 20'd0, 14'd0, 15'sh4000);
		queue_random(100);
		drain();

		// Reset values again, with one long output hold so the pipeline fills and stalls.
		set_all(ntc_pkg::SERIES_RST, ntc_pkg::NOMINAL_RST, ntc_pkg::BETA_RST, ntc_pkg::T0_RST);
		send_idle_pct = 0;
		queue_random(200);
		hold_req <= 1'b1;
		drain();

		// Random plausible thermistor settings.
		for (int p = 0; p < 2; p++) begin
			send_idle_pct = 15;
			recv_idle_pct = 20;
			set_all(20'($urandom_range(1000000, 1)), 20'($urandom_range(1000000, 1)),
				14'($urandom_range(10000, 1)), 15'($urandom_range(20000, 0) - 5000));
			queue_random(120);
			drain();
		end

		// Final stretch with no idling on either side.
		set_all(20'd4700, 20'd100000, 14'd4250, -15'sd5000);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(100);
		drain();

		if (mismatches == 0 && expected_temps.size() == 0) begin
			$display("** ntc_thermistor_to_temperature: PASSED **");
		end else begin
			$display("** ntc_thermistor_to_temperature: FAILED **");
		end
		$finish;
	end

endmodule
